// ===== rtl/lslf_pkg.sv =====
// Shared types and constants for the least-squares line fit block.
package lslf_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int RESULT_W     = 32;
  // Quotient bits kept by the divider: 32 result bits plus two for overflow.
  localparam int QUOT_W       = 34;
  localparam int SLOPE_SHIFT  = 16;
  localparam int INTC_SHIFT   = 8;

  // Product codes for the shared multiplier, in issue order.
  localparam logic [2:0] MUL_N_SXX  = 3'd0;
  localparam logic [2:0] MUL_SX_SX  = 3'd1;
  localparam logic [2:0] MUL_N_SXY  = 3'd2;
  localparam logic [2:0] MUL_SX_SY  = 3'd3;
  localparam logic [2:0] MUL_SY_SXX = 3'd4;
  localparam logic [2:0] MUL_SX_SXY = 3'd5;

  // Divider target codes.
  localparam logic DIV_SLOPE = 1'b0;
  localparam logic DIV_INTC  = 1'b1;

  typedef struct packed {
    logic       sample_en;
    logic       clear;
    logic       mul_start;
    logic [2:0] mul_sel;
    logic       div_start;
    logic       div_sel;
    logic       load_out;
    logic       degen;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic den_zero;
  } sts_t;

endpackage

// ===== rtl/lslf_mul.sv =====
// Bit-serial signed multiplier: one shift-add step per cycle, stops early.
module lslf_mul #(
  parameter int OPW = 42
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [OPW-1:0] op_a,
  input  logic signed [OPW-1:0] op_b,
  output logic                  done,
  output logic                  prod_neg,
  output logic [2*OPW-1:0]      prod_mag
);

  localparam int PW = 2 * OPW;

  logic           busy_r, busy_nxt;
  logic           neg_r;
  logic [PW-1:0]  mcand_r;
  logic [OPW-1:0] mplier_r;
  logic [PW-1:0]  acc_r;
  logic [OPW-1:0] a_mag, b_mag;

  assign a_mag = op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a);
  assign b_mag = op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);

  assign done     = busy_r && (mplier_r == '0);
  assign prod_neg = neg_r;
  assign prod_mag = acc_r;

  always_comb begin
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r    <= op_a[OPW-1] ^ op_b[OPW-1];
      mcand_r  <= PW'(a_mag);
      mplier_r <= b_mag;
      acc_r    <= '0;
    end else if (busy_r && !done) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

endmodule

// ===== rtl/lslf_div.sv =====
// Restoring divider giving a rounded, saturated signed 32-bit fixed-point quotient.
module lslf_div #(
  parameter int NUMW = 85
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              shift_sel,
  input  logic signed [NUMW-1:0]            num,
  input  logic signed [NUMW-1:0]            den,
  output logic                              done,
  output logic [lslf_pkg::RESULT_W-1:0]     quot
);

  localparam int QW   = lslf_pkg::QUOT_W;
  localparam int DVW  = NUMW + QW;
  localparam int CNTW = $clog2(QW + 1);
  localparam int RW   = lslf_pkg::RESULT_W;

  logic            busy_r, busy_nxt;
  logic            neg_r;
  logic [DVW-1:0]  rem_r;
  logic [DVW-1:0]  dsh_r;
  logic [QW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic [NUMW-1:0] num_mag, den_mag;
  logic [DVW-1:0]  rem_init;
  logic [RW-1:0]   limit;
  logic [RW-1:0]   mag;
  logic            sat;

  assign num_mag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
  assign den_mag = den[NUMW-1] ? NUMW'(-den) : NUMW'(den);

  // Rounding to nearest: (2*|num|*2^s + |den|) / (2*|den|).
  always_comb begin
    if (shift_sel == lslf_pkg::DIV_SLOPE) begin
      rem_init = (DVW'(num_mag) << (lslf_pkg::SLOPE_SHIFT + 1)) + DVW'(den_mag);
    end else begin
      rem_init = (DVW'(num_mag) << (lslf_pkg::INTC_SHIFT + 1)) + DVW'(den_mag);
    end
  end

  assign done  = busy_r && (cnt_r == CNTW'(QW));
  assign limit = neg_r ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
  assign sat   = (q_r[QW-1:RW] != '0) || (q_r[RW-1:0] > limit);
  assign mag   = sat ? limit : q_r[RW-1:0];
  assign quot  = neg_r ? RW'(-mag) : mag;

  always_comb begin
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUMW-1] ^ den[NUMW-1];
      rem_r <= rem_init;
      // Twice the divisor, aligned to the top quotient bit.
      dsh_r <= DVW'(den_mag) << QW;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r && !done) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule

// ===== rtl/lslf_dpath.sv =====
// Datapath: running sums, shared multiplier and divider, held and output results.
module lslf_dpath #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lslf_pkg::cmd_t                        cmd,
  output lslf_pkg::sts_t                        sts,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0]  in_x_value,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0]  in_y_value,
  output logic signed [lslf_pkg::RESULT_W-1:0]  out_slope,
  output logic signed [lslf_pkg::RESULT_W-1:0]  out_intercept,
  output logic                                  out_degenerate
);

  localparam int SW   = lslf_pkg::SAMPLE_W;
  localparam int RW   = lslf_pkg::RESULT_W;
  localparam int L    = $clog2(MAX_SAMPLES);
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int SXW  = SW + 1 + L;
  localparam int SPW  = 2 * SW + L;
  localparam int SQW  = 2 * SW - 1 + L;
  localparam int OPW  = SPW;
  localparam int PW   = 2 * OPW;
  localparam int NUMW = PW + 1;

  logic        [CW-1:0]    count_r;
  logic signed [SXW-1:0]   sx_r, sy_r;
  logic signed [SPW-1:0]   sxy_r;
  logic        [SQW-1:0]   sxx_r;
  logic signed [2*SW-1:0]  xy, xx;

  logic signed [OPW-1:0]   op_a, op_b;
  logic        [2:0]       mul_idx_r;
  logic                    mul_done, prod_neg;
  logic        [PW-1:0]    prod_mag;
  logic signed [PW-1:0]    hold_r;
  logic signed [NUMW-1:0]  diff;
  logic signed [NUMW-1:0]  den_r, nums_r, numi_r;

  logic                    div_sel_r;
  logic                    div_done;
  logic        [RW-1:0]    quot;
  logic signed [NUMW-1:0]  div_num;

  logic        [RW-1:0]    held_slope_r, held_intc_r;
  logic        [RW-1:0]    out_slope_r, out_intc_r;
  logic                    out_degen_r;

  assign xy = in_x_value * in_y_value;
  assign xx = in_x_value * in_x_value;

  // Accumulation; samples past the batch limit are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxy_r   <= '0;
      sxx_r   <= '0;
    end else if (cmd.sample_en && (count_r < CW'(MAX_SAMPLES))) begin
      count_r <= count_r + 1'b1;
      sx_r    <= sx_r + SXW'(in_x_value);
      sy_r    <= sy_r + SXW'(in_y_value);
      sxy_r   <= sxy_r + SPW'(xy);
      sxx_r   <= sxx_r + SQW'($unsigned(xx));
    end
  end

  // The narrower operand goes to the serial side so the multiply ends sooner.
  always_comb begin
    unique case (cmd.mul_sel)
      lslf_pkg::MUL_N_SXX: begin
        op_b = OPW'({1'b0, count_r});
        op_a = OPW'({1'b0, sxx_r});
      end
      lslf_pkg::MUL_SX_SX: begin
        op_b = OPW'(sx_r);
        op_a = OPW'(sx_r);
      end
      lslf_pkg::MUL_N_SXY: begin
        op_b = OPW'({1'b0, count_r});
        op_a = OPW'(sxy_r);
      end
      lslf_pkg::MUL_SX_SY: begin
        op_b = OPW'(sx_r);
        op_a = OPW'(sy_r);
      end
      lslf_pkg::MUL_SY_SXX: begin
        op_b = OPW'(sy_r);
        op_a = OPW'({1'b0, sxx_r});
      end
      lslf_pkg::MUL_SX_SXY: begin
        op_b = OPW'(sx_r);
        op_a = OPW'(sxy_r);
      end
      default: begin
        op_b = '0;
        op_a = '0;
      end
    endcase
  end

  lslf_mul #(
    .OPW (OPW)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mul_start),
    .op_a     (op_a),
    .op_b     (op_b),
    .done     (mul_done),
    .prod_neg (prod_neg),
    .prod_mag (prod_mag)
  );

  // Second product of each pair is subtracted from the first.
  assign diff = prod_neg ? NUMW'(hold_r) + $signed({1'b0, prod_mag})
                         : NUMW'(hold_r) - $signed({1'b0, prod_mag});

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mul_idx_r <= cmd.mul_sel;
    end
    if (mul_done) begin
      case (mul_idx_r) inside
        lslf_pkg::MUL_N_SXX, lslf_pkg::MUL_N_SXY, lslf_pkg::MUL_SY_SXX: begin
          hold_r <= prod_neg ? PW'(-$signed(prod_mag)) : $signed(prod_mag);
        end
        lslf_pkg::MUL_SX_SX:  den_r  <= diff;
        lslf_pkg::MUL_SX_SY:  nums_r <= diff;
        lslf_pkg::MUL_SX_SXY: numi_r <= diff;
        default: ;
      endcase
    end
  end

  assign div_num = (cmd.div_sel == lslf_pkg::DIV_SLOPE) ? nums_r : numi_r;

  lslf_div #(
    .NUMW (NUMW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .shift_sel (cmd.div_sel),
    .num       (div_num),
    .den       (den_r),
    .done      (div_done),
    .quot      (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel_r <= cmd.div_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_slope_r <= '0;
      held_intc_r  <= '0;
    end else if (div_done) begin
      if (div_sel_r == lslf_pkg::DIV_SLOPE) begin
        held_slope_r <= quot;
      end else begin
        held_intc_r <= quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_slope_r <= held_slope_r;
      out_intc_r  <= held_intc_r;
      out_degen_r <= cmd.degen;
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.den_zero = (den_r == '0);

  assign out_slope      = $signed(out_slope_r);
  assign out_intercept  = $signed(out_intc_r);
  assign out_degenerate = out_degen_r;

endmodule

// ===== rtl/lslf_ctrl.sv =====
// Controller: sequences accumulation, the six products and the two divisions.
module lslf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last_sample,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output lslf_pkg::cmd_t cmd,
  input  lslf_pkg::sts_t sts
);

  localparam logic [2:0] ST_ACC      = 3'd0;
  localparam logic [2:0] ST_MUL_GO   = 3'd1;
  localparam logic [2:0] ST_MUL_WAIT = 3'd2;
  localparam logic [2:0] ST_CHK      = 3'd3;
  localparam logic [2:0] ST_DIV_GO   = 3'd4;
  localparam logic [2:0] ST_DIV_WAIT = 3'd5;
  localparam logic [2:0] ST_OUT      = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       dsel_r, dsel_nxt;
  logic       degen_r, degen_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != ST_ACC);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    dsel_nxt      = dsel_r;
    degen_nxt     = degen_r;
    cmd           = '0;
    cmd.mul_sel   = idx_r;
    cmd.div_sel   = dsel_r;
    cmd.degen     = degen_r;

    unique case (state_r)
      ST_ACC: begin
        if (in_valid) begin
          cmd.sample_en = 1'b1;
          if (in_last_sample) begin
            idx_nxt   = lslf_pkg::MUL_N_SXX;
            state_nxt = ST_MUL_GO;
          end
        end
      end
      ST_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (sts.mul_done) begin
          if (idx_r == lslf_pkg::MUL_SX_SXY) begin
            state_nxt = ST_CHK;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_MUL_GO;
          end
        end
      end
      ST_CHK: begin
        // Products are done, so the sums are free for the next batch.
        cmd.clear = 1'b1;
        if (sts.den_zero) begin
          degen_nxt = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          degen_nxt = 1'b0;
          dsel_nxt  = lslf_pkg::DIV_SLOPE;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          if (dsel_r == lslf_pkg::DIV_SLOPE) begin
            dsel_nxt  = lslf_pkg::DIV_INTC;
            state_nxt = ST_DIV_GO;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      idx_r       <= lslf_pkg::MUL_N_SXX;
      dsel_r      <= lslf_pkg::DIV_SLOPE;
      degen_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      dsel_r      <= dsel_nxt;
      degen_r     <= degen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/least_squares_line_fit.sv =====
// Least-squares line fit over batches of Q8.8 samples, giving Q16.16 slope and intercept.
//
// Input channel: in_x_value and in_y_value carry one signed Q8.8 sample per transfer;
// in_last_sample marks the final sample of a batch. While a batch is being collected
// the block takes one sample per cycle. Samples beyond MAX_SAMPLES in one batch are
// dropped, but a last marker still starts the fit.
// Result channel: one transfer per batch carries out_slope and out_intercept (signed
// Q16.16, rounded to nearest and saturated) and out_degenerate. When the fit's
// denominator is zero, out_degenerate is set and the previous slope and intercept are
// repeated.
// After the last sample, six products run on one bit-serial multiplier, one bit of the
// narrower operand per cycle, then two divisions on a restoring divider at one quotient
// bit per cycle. in_stall is high while they run, and out_valid rises as in_stall falls.
// A zero denominator skips the divisions.
// A finished result waits in the output register while the next batch is collected;
// if the receiver still stalls when the next fit is ready, the block waits for it.
// Reset clears the sums, the held slope and intercept, and the output valid.
module least_squares_line_fit #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0]  in_x_value,
  input  logic signed [lslf_pkg::SAMPLE_W-1:0]  in_y_value,
  input  logic                                  in_last_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lslf_pkg::RESULT_W-1:0]  out_slope,
  output logic signed [lslf_pkg::RESULT_W-1:0]  out_intercept,
  output logic                                  out_degenerate
);

  lslf_pkg::cmd_t cmd;
  lslf_pkg::sts_t sts;

  lslf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_sample (in_last_sample),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .sts            (sts)
  );

  lslf_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_x_value     (in_x_value),
    .in_y_value     (in_y_value),
    .out_slope      (out_slope),
    .out_intercept  (out_intercept),
    .out_degenerate (out_degenerate)
  );

endmodule
